[sv/dqvt_pkg.sv]
// Shared widths, constants and divider handshake types for the dual
// quadrature velocity tracker. No dependencies.
`default_nettype none
package dqvt_pkg;

   localparam int COUNT_W   = 16;
   localparam int SUM_W     = 32;
   localparam int RATE_W    = 26;
   localparam int MS_W      = 32;
   localparam int IVL_W     = 16;
   localparam int QUO_W     = 25;               // |step| * 1000 < 2**25
   localparam int QCNT_W    = $clog2(QUO_W + 1);
   localparam int ACC_CNT_W = $clog2(SUM_W);

   localparam logic [QUO_W-1:0]  RATE_SCALE   = QUO_W'(1000);
   localparam logic [IVL_W-1:0]  INTERVAL_MAX = '1;

   localparam logic FUNC_UPDATE     = 1'b0;
   localparam logic FUNC_REBASELINE = 1'b1;

   typedef struct packed {
      logic             start;
      logic [QUO_W-1:0] dividend;
      logic [MS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

[sv/dqvt_req_if.sv]
// Input channel: valid/ready handshake carrying one sample word.
// Depends on dqvt_pkg.
`default_nettype none
interface dqvt_req_if;
   import dqvt_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [COUNT_W-1:0] left_count;
   logic [COUNT_W-1:0] right_count;
   logic [MS_W-1:0]    span_ms;

   modport source (output valid, func, left_count, right_count, span_ms, input ready);
   modport sink   (input valid, func, left_count, right_count, span_ms, output ready);
endinterface
`default_nettype wire

[sv/dqvt_rsp_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on dqvt_pkg.
`default_nettype none
interface dqvt_rsp_if;
   import dqvt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] left_step;
   logic signed [COUNT_W-1:0] right_step;
   logic signed [SUM_W-1:0]   left_sum;
   logic signed [SUM_W-1:0]   right_sum;
   logic signed [RATE_W-1:0]  left_rate;
   logic signed [RATE_W-1:0]  right_rate;
   logic [IVL_W-1:0]          interval_out;

   modport source (output valid, left_step, right_step, left_sum, right_sum, left_rate,
                   right_rate, interval_out, input ready);
   modport sink   (input valid, left_step, right_step, left_sum, right_sum, left_rate,
                   right_rate, interval_out, output ready);
endinterface
`default_nettype wire

[sv/dqvt_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dqvt_pkg.
`default_nettype none
module dqvt_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  dqvt_pkg::div_req_type req,
   output dqvt_pkg::div_rsp_type rsp
);
   import dqvt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [MS_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;   // dividend bits out the top, quotient in the bottom

   logic [MS_W:0] trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      ge      = trial >= {1'b0, req.divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = QCNT_W'(QUO_W);
         rem_in  = '0;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top trial bit drops out
         rem_in = ge ? MS_W'(trial - {1'b0, req.divisor}) : trial[MS_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

[sv/dual_quadrature_velocity_tracker.sv]
// Dual quadrature velocity tracker, top level.
// Depends on dqvt_pkg, dqvt_req_if, dqvt_rsp_if and dqvt_divider.
//
// Usage:
//   req_chan carries one sample word: func, left_count, right_count, span_ms.
//   func update gives the wrap-aware 16-bit steps, the 32-bit running sums,
//   counts per second (step * 1000 / span_ms, toward zero) and the
//   saturated interval. func rebaseline captures the counts, clears the sums
//   and returns an all-zero word.
//   rsp_chan returns exactly one word per accepted sample, in order.
// Sequencing:
//   A sample with nonzero span_ms runs two divisions, left then right, on one
//   shared bit-serial divider. The sums take a bit-serial add in parallel, and
//   the result waits for it; a zero-interval sample runs only the add and a
//   rebaseline neither.
//   req_chan.ready is high only while no sample is in flight.
// Reset: synchronous, clears counts, sums and the handshake state.
// Stall: the result sits in an output register; the next sample is accepted
//   and processed while it waits, and that sample's result waits in turn
//   until rsp_chan.ready frees the register.
`default_nettype none
module dual_quadrature_velocity_tracker (
   input  wire        clock,
   input  wire        reset,
   dqvt_req_if.sink   req_chan,
   dqvt_rsp_if.source rsp_chan
);
   import dqvt_pkg::*;

   typedef enum logic [2:0] {IDLE, START_L, WAIT_L, START_R, WAIT_R, FINISH} state_type;

   state_type state_ff;

   logic [COUNT_W-1:0]        left_last_ff, right_last_ff;
   logic [SUM_W-1:0]          left_accum_ff, right_accum_ff;
   logic signed [COUNT_W-1:0] left_step_ff, right_step_ff;
   logic [COUNT_W-1:0]        left_sh_ff, right_sh_ff;
   logic                      left_cy_ff, right_cy_ff;
   logic                      acc_busy_ff;
   logic [ACC_CNT_W-1:0]      acc_cnt_ff;
   logic signed [RATE_W-1:0]  left_rate_ff, right_rate_ff;
   logic [MS_W-1:0]           ms_ff;
   logic [IVL_W-1:0]          ivl_ff;

   logic                      rsp_valid_ff;
   logic signed [COUNT_W-1:0] rsp_left_step_ff, rsp_right_step_ff;
   logic signed [SUM_W-1:0]   rsp_left_sum_ff, rsp_right_sum_ff;
   logic signed [RATE_W-1:0]  rsp_left_rate_ff, rsp_right_rate_ff;
   logic [IVL_W-1:0]          rsp_ivl_ff;

   logic               req_fire, load_rsp;
   logic [COUNT_W-1:0] left_step_in, right_step_in;
   logic [COUNT_W-1:0] sel_step, sel_mag;
   logic               l_sum_bit, r_sum_bit;
   logic [RATE_W-1:0]  quo_ext;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_chan.ready = (state_ff == IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_rsp       = (state_ff == FINISH) && !acc_busy_ff
                           && (!rsp_valid_ff || rsp_chan.ready);

   assign left_step_in  = req_chan.left_count - left_last_ff;
   assign right_step_in = req_chan.right_count - right_last_ff;

   // divider feed: |step| * 1000, the sign is reapplied on the quotient
   assign sel_step         = (state_ff == START_L) ? left_step_ff : right_step_ff;
   assign sel_mag          = sel_step[COUNT_W-1] ? COUNT_W'(~sel_step + 1'b1) : sel_step;
   assign div_req.start    = (state_ff == START_L) || (state_ff == START_R);
   assign div_req.dividend = QUO_W'(QUO_W'(sel_mag) * RATE_SCALE);
   assign div_req.divisor  = ms_ff;
   assign quo_ext          = RATE_W'(div_rsp.quotient);

   dqvt_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // bit-serial sum: accumulator rotates LSB first, step copy shifts with sign fill
   assign l_sum_bit = left_accum_ff[0] ^ left_sh_ff[0] ^ left_cy_ff;
   assign r_sum_bit = right_accum_ff[0] ^ right_sh_ff[0] ^ right_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         left_last_ff   <= '0;
         right_last_ff  <= '0;
         left_accum_ff  <= '0;
         right_accum_ff <= '0;
         acc_busy_ff    <= 1'b0;
         acc_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (acc_busy_ff) begin
            left_accum_ff  <= {l_sum_bit, left_accum_ff[SUM_W-1:1]};
            right_accum_ff <= {r_sum_bit, right_accum_ff[SUM_W-1:1]};
            left_cy_ff     <= (left_accum_ff[0] & left_sh_ff[0])
                              | (left_cy_ff & (left_accum_ff[0] ^ left_sh_ff[0]));
            right_cy_ff    <= (right_accum_ff[0] & right_sh_ff[0])
                              | (right_cy_ff & (right_accum_ff[0] ^ right_sh_ff[0]));
            left_sh_ff     <= {left_sh_ff[COUNT_W-1], left_sh_ff[COUNT_W-1:1]};
            right_sh_ff    <= {right_sh_ff[COUNT_W-1], right_sh_ff[COUNT_W-1:1]};
            acc_cnt_ff     <= acc_cnt_ff - 1'b1;
            if (acc_cnt_ff == '0) begin
               acc_busy_ff <= 1'b0;
            end
         end

         case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  left_last_ff  <= req_chan.left_count;
                  right_last_ff <= req_chan.right_count;
                  ms_ff         <= req_chan.span_ms;
                  left_rate_ff  <= '0;
                  right_rate_ff <= '0;
                  if (req_chan.func == FUNC_REBASELINE) begin
                     left_accum_ff  <= '0;
                     right_accum_ff <= '0;
                     left_step_ff   <= '0;
                     right_step_ff  <= '0;
                     ivl_ff         <= '0;
                     state_ff       <= FINISH;
                  end else begin
                     left_step_ff  <= left_step_in;
                     right_step_ff <= right_step_in;
                     left_sh_ff    <= left_step_in;
                     right_sh_ff   <= right_step_in;
                     left_cy_ff    <= 1'b0;
                     right_cy_ff   <= 1'b0;
                     acc_busy_ff   <= 1'b1;
                     acc_cnt_ff    <= ACC_CNT_W'(SUM_W - 1);
                     if (req_chan.span_ms == '0) begin
                        ivl_ff   <= '0;
                        state_ff <= FINISH;
                     end else begin
                        ivl_ff   <= (req_chan.span_ms > MS_W'(INTERVAL_MAX))
                                    ? INTERVAL_MAX : req_chan.span_ms[IVL_W-1:0];
                        state_ff <= START_L;
                     end
                  end
               end
            end
            START_L: begin
               state_ff <= WAIT_L;
            end
            WAIT_L: begin
               if (div_rsp.done) begin
                  left_rate_ff <= left_step_ff[COUNT_W-1] ? RATE_W'(~quo_ext + 1'b1) : quo_ext;
                  state_ff     <= START_R;
               end
            end
            START_R: begin
               state_ff <= WAIT_R;
            end
            WAIT_R: begin
               if (div_rsp.done) begin
                  right_rate_ff <= right_step_ff[COUNT_W-1] ? RATE_W'(~quo_ext + 1'b1)
                                                            : quo_ext;
                  state_ff      <= FINISH;
               end
            end
            FINISH: begin
               if (load_rsp) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_left_step_ff  <= left_step_ff;
         rsp_right_step_ff <= right_step_ff;
         rsp_left_sum_ff   <= left_accum_ff;
         rsp_right_sum_ff  <= right_accum_ff;
         rsp_left_rate_ff  <= left_rate_ff;
         rsp_right_rate_ff <= right_rate_ff;
         rsp_ivl_ff        <= ivl_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_step    = rsp_left_step_ff;
   assign rsp_chan.right_step   = rsp_right_step_ff;
   assign rsp_chan.left_sum     = rsp_left_sum_ff;
   assign rsp_chan.right_sum    = rsp_right_sum_ff;
   assign rsp_chan.left_rate    = rsp_left_rate_ff;
   assign rsp_chan.right_rate   = rsp_right_rate_ff;
   assign rsp_chan.interval_out = rsp_ivl_ff;

   // a word is only loaded out of FINISH
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FINISH))
      else $error("result word raised outside FINISH");

   // serial sum of the previous sample must be complete before a new one
   a_accum_idle_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !acc_busy_ff)
      else $error("sample accepted while sum still shifting");

   // divider completions only land while a wait state expects them
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == WAIT_L || state_ff == WAIT_R))
      else $error("unexpected divider completion");

   a_rebaseline_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func == FUNC_REBASELINE)
      |=> (left_accum_ff == '0 && right_accum_ff == '0 && state_ff == FINISH))
      else $error("rebaseline did not clear sums");

endmodule
`default_nettype wire

[bench/dqvt_velocity_checker.sv]
`timescale 1ns / 100ps
// Watches the sample and result channels of the velocity tracker, predicts each result word
// and compares it field by field. Depends on dqvt_pkg, dqvt_req_if and dqvt_rsp_if.
module dqvt_velocity_checker (
   input  logic clock,
   input  logic reset,
   dqvt_req_if  req_mon,
   dqvt_rsp_if  rsp_mon,
   output int   mismatches,
   output int   pending
);
   import dqvt_pkg::*;

   typedef struct packed {
      logic signed [COUNT_W-1:0] left_step;
      logic signed [COUNT_W-1:0] right_step;
      logic signed [SUM_W-1:0]   left_sum;
      logic signed [SUM_W-1:0]   right_sum;
      logic signed [RATE_W-1:0]  left_rate;
      logic signed [RATE_W-1:0]  right_rate;
      logic [IVL_W-1:0]          interval;
   } velocity_word_type;

   logic [COUNT_W-1:0] left_prev, right_prev;
   logic [SUM_W-1:0]   left_acc, right_acc;
   velocity_word_type  expected_words[$];
   int                 fail_tally = 0;
   int                 backlog = 0;

   assign mismatches = fail_tally;
   assign pending    = backlog;

   // step * 1000 / ms, truncated toward zero, kept to the rate width
   function automatic logic signed [RATE_W-1:0] counts_per_sec(input logic [COUNT_W-1:0] step,
                                                               input logic [MS_W-1:0] ms);
      logic [63:0] mag;
      logic [63:0] quot;
      mag  = step[COUNT_W-1] ? 64'(17'h10000 - 17'(step)) : 64'(step);
      quot = (mag * 64'(RATE_SCALE)) / 64'(ms);
      if (step[COUNT_W-1])
         quot = 64'd0 - quot;
      return quot[RATE_W-1:0];
   endfunction

   function automatic velocity_word_type track_sample(input logic func,
                                                      input logic [COUNT_W-1:0] left_now,
                                                      input logic [COUNT_W-1:0] right_now,
                                                      input logic [MS_W-1:0] ms);
      velocity_word_type word;
      logic [COUNT_W-1:0] ls, rs;
      word = '0;
      if (func == FUNC_REBASELINE) begin
         left_prev  = left_now;
         right_prev = right_now;
         left_acc   = '0;
         right_acc  = '0;
         return word;
      end
      ls         = left_now - left_prev;
      rs         = right_now - right_prev;
      left_prev  = left_now;
      right_prev = right_now;
      left_acc   = left_acc + SUM_W'(signed'(ls));
      right_acc  = right_acc + SUM_W'(signed'(rs));
      word.left_step  = ls;
      word.right_step = rs;
      word.left_sum   = left_acc;
      word.right_sum  = right_acc;
      if (ms != '0) begin
         word.left_rate  = counts_per_sec(ls, ms);
         word.right_rate = counts_per_sec(rs, ms);
         word.interval   = (ms > MS_W'(INTERVAL_MAX)) ? INTERVAL_MAX : ms[IVL_W-1:0];
      end
      return word;
   endfunction

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      velocity_word_type want;
      if (reset) begin
         left_prev  = '0;
         right_prev = '0;
         left_acc   = '0;
         right_acc  = '0;
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no sample pending");
               fail_tally++;
            end else begin
               want = expected_words.pop_front();
               compare_field("left_step", want.left_step, rsp_mon.left_step);
               compare_field("right_step", want.right_step, rsp_mon.right_step);
               compare_field("left_sum", want.left_sum, rsp_mon.left_sum);
               compare_field("right_sum", want.right_sum, rsp_mon.right_sum);
               compare_field("left_rate", want.left_rate, rsp_mon.left_rate);
               compare_field("right_rate", want.right_rate, rsp_mon.right_rate);
               compare_field("interval_out", want.interval, rsp_mon.interval_out);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(track_sample(req_mon.func, req_mon.left_count,
                                                  req_mon.right_count, req_mon.span_ms));
      end
      backlog <= expected_words.size();
   end

endmodule

[bench/tb_dual_quadrature_velocity_tracker.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the dual quadrature velocity tracker: directed corner samples,
// then random encoder traffic with idles on both sides. Depends on dqvt_velocity_checker.
module tb_dual_quadrature_velocity_tracker;
   import dqvt_pkg::*;

   localparam int CYCLE_LIMIT  = 1_200_000;
   localparam int LONG_HOLD    = 700;
   localparam int RANDOM_WORDS = 750;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   mismatches;
   int   pending;
   logic hold_request = 1'b0;
   logic steady = 1'b0;
   logic [COUNT_W-1:0] left_seen = '0, right_seen = '0;

   dqvt_req_if req_chan ();
   dqvt_rsp_if rsp_chan ();

   dual_quadrature_velocity_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dqvt_velocity_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 150);
   endfunction

   function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] prev);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return prev + COUNT_W'($urandom_range(0, 600)) - COUNT_W'(300);
      if (r < 8) return prev + COUNT_W'(16'h8000) + COUNT_W'($urandom_range(0, 4)) - COUNT_W'(2);
      return COUNT_W'($urandom);
   endfunction

   function automatic logic [MS_W-1:0] pick_interval();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 55) return MS_W'($urandom_range(1, 20));
      if (r < 85) return MS_W'($urandom_range(21, 70000));
      return MS_W'($urandom);
   endfunction

   task automatic offer_sample(input logic func, input logic [COUNT_W-1:0] left_now,
                               input logic [COUNT_W-1:0] right_now, input logic [MS_W-1:0] ms);
      req_chan.func        <= func;
      req_chan.left_count  <= left_now;
      req_chan.right_count <= right_now;
      req_chan.span_ms     <= ms;
      req_chan.valid       <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      left_seen  = left_now;
      right_seen = right_now;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // receiver: random stalls, one long hold-off per request, steady stretches with none
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!steady) begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      logic func;
      logic busy_window;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.func        <= FUNC_UPDATE;
      req_chan.left_count  <= '0;
      req_chan.right_count <= '0;
      req_chan.span_ms     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: zero time, half-range steps, wraps, saturation, rebaseline
      offer_sample(FUNC_UPDATE, 16'h0000, 16'h0000, 32'd0);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h8000, 16'h7FFF, 32'd1);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h0000, 16'hFFFF, 32'd1000);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'hFFFF, 16'h0000, 32'd3);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h0005, 16'hFFF0, 32'hFFFF_FFFF);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h0105, 16'hFEF0, 32'd65535);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h0205, 16'hFDF0, 32'd65536);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h0206, 16'hFDF0, 32'd0);
      idle_sender(pick_gap());
      offer_sample(FUNC_REBASELINE, 16'h1234, 16'hFFFF, 32'd77);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h123B, 16'h0002, 32'd7);
      idle_sender(pick_gap());
      offer_sample(FUNC_REBASELINE, 16'h0000, 16'h0000, 32'd0);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'h7FFF, 16'h8001, 32'd2);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'hFFFF, 16'h0001, 32'd1);
      idle_sender(pick_gap());
      offer_sample(FUNC_UPDATE, 16'hFFFF, 16'h0001, 32'h8000_0000);
      idle_sender(pick_gap());
      offer_sample(FUNC_REBASELINE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      idle_sender(pick_gap());

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 120 || i == 520)
            hold_request = 1'b1;
         steady      = (i >= 300 && i < 380);
         busy_window = steady || (i >= 120 && i < 140) || (i >= 520 && i < 540);
         func = ($urandom_range(0, 9) == 0) ? FUNC_REBASELINE : FUNC_UPDATE;
         offer_sample(func, next_count(left_seen), next_count(right_seen), pick_interval());
         idle_sender(busy_window ? 0 : pick_gap());
      end
      req_chan.valid <= 1'b0;
      steady = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
sv/dqvt_pkg.sv
sv/dqvt_req_if.sv
sv/dqvt_rsp_if.sv
sv/dqvt_divider.sv
sv/dual_quadrature_velocity_tracker.sv
bench/dqvt_velocity_checker.sv
bench/tb_dual_quadrature_velocity_tracker.sv
